FILE: hw/rtl/sst_pkg.sv
package sst_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int KW_CHARS     = 8;
  localparam int KW_COUNT     = 20;
  localparam int QDEPTH       = 4;
  localparam int MAX_RES      = 3;

  typedef logic [5:0] kind_t;

  localparam kind_t K_NUMBER  = 6'd0;
  localparam kind_t K_STRING  = 6'd1;
  localparam kind_t K_INTERP  = 6'd2;
  localparam kind_t K_IDENT   = 6'd3;
  localparam kind_t K_KEYWORD = 6'd4;
  localparam kind_t K_PLUS    = 6'd24;
  localparam kind_t K_PLUSEQ  = 6'd25;
  localparam kind_t K_MINUS   = 6'd26;
  localparam kind_t K_MINUSEQ = 6'd27;
  localparam kind_t K_ARROW   = 6'd28;
  localparam kind_t K_STAR    = 6'd29;
  localparam kind_t K_SLASH   = 6'd30;
  localparam kind_t K_PERCENT = 6'd31;
  localparam kind_t K_ASSIGN  = 6'd32;
  localparam kind_t K_EQ      = 6'd33;
  localparam kind_t K_FATARR  = 6'd34;
  localparam kind_t K_NOT     = 6'd35;
  localparam kind_t K_NE      = 6'd36;
  localparam kind_t K_LT      = 6'd37;
  localparam kind_t K_LE      = 6'd38;
  localparam kind_t K_GT      = 6'd39;
  localparam kind_t K_GE      = 6'd40;
  localparam kind_t K_ANDAND  = 6'd41;
  localparam kind_t K_OROR    = 6'd42;
  localparam kind_t K_PIPE    = 6'd43;
  localparam kind_t K_LPAREN  = 6'd44;
  localparam kind_t K_RPAREN  = 6'd45;
  localparam kind_t K_LBRACE  = 6'd46;
  localparam kind_t K_RBRACE  = 6'd47;
  localparam kind_t K_LBRACK  = 6'd48;
  localparam kind_t K_RBRACK  = 6'd49;
  localparam kind_t K_DOT     = 6'd50;
  localparam kind_t K_COMMA   = 6'd51;
  localparam kind_t K_SEMI    = 6'd52;
  localparam kind_t K_COLON   = 6'd53;
  localparam kind_t K_ERROR   = 6'd54;
  localparam kind_t K_EOF     = 6'd55;

  // keyword text, right-justified, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("var"), 64'("func"), 64'("class"), 64'("return"), 64'("if"),
    64'("else"), 64'("while"), 64'("for"), 64'("break"), 64'("continue"),
    64'("new"), 64'("this"), 64'("try"), 64'("catch"), 64'("finally"),
    64'("throw"), 64'("extends"), 64'("true"), 64'("false"), 64'("null")};
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8,
    4'd3, 4'd4, 4'd3, 4'd5, 4'd7, 4'd5, 4'd7, 4'd4, 4'd5, 4'd4};

  typedef logic [KW_CHARS-1:0][7:0] wbuf_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    kind_t       token_kind;
    logic [7:0]  text_byte;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] token_length;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                cnt;
    out_item_t [MAX_RES-1:0]   res;
  } q_entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_held_op(input logic [7:0] c);
    is_held_op = (c == "+") || (c == "-") || (c == "=") || (c == "!") ||
                 (c == "<") || (c == ">") || (c == "&") || (c == "|");
  endfunction

  function automatic kind_t single_code(input logic [7:0] c);
    case (c)
      "*":     single_code = K_STAR;
      "/":     single_code = K_SLASH;
      "%":     single_code = K_PERCENT;
      "(":     single_code = K_LPAREN;
      ")":     single_code = K_RPAREN;
      "{":     single_code = K_LBRACE;
      "}":     single_code = K_RBRACE;
      "[":     single_code = K_LBRACK;
      "]":     single_code = K_RBRACK;
      ".":     single_code = K_DOT;
      ",":     single_code = K_COMMA;
      ";":     single_code = K_SEMI;
      ":":     single_code = K_COLON;
      default: single_code = K_ERROR;
    endcase
  endfunction

  function automatic kind_t alone_code(input logic [7:0] h);
    case (h)
      "+":     alone_code = K_PLUS;
      "-":     alone_code = K_MINUS;
      "=":     alone_code = K_ASSIGN;
      "!":     alone_code = K_NOT;
      "<":     alone_code = K_LT;
      ">":     alone_code = K_GT;
      default: alone_code = K_ERROR;
    endcase
  endfunction

  // zero when the pair forms no operator
  function automatic kind_t pair_code(input logic [7:0] h, input logic [7:0] c);
    pair_code = K_NUMBER;
    if (h == "+" && c == "=") pair_code = K_PLUSEQ;
    if (h == "-" && c == "=") pair_code = K_MINUSEQ;
    if (h == "-" && c == ">") pair_code = K_ARROW;
    if (h == "=" && c == "=") pair_code = K_EQ;
    if (h == "=" && c == ">") pair_code = K_FATARR;
    if (h == "!" && c == "=") pair_code = K_NE;
    if (h == "<" && c == "=") pair_code = K_LE;
    if (h == ">" && c == "=") pair_code = K_GE;
    if (h == "&" && c == "&") pair_code = K_ANDAND;
    if (h == "|" && c == "|") pair_code = K_OROR;
    if (h == "|" && c == ">") pair_code = K_PIPE;
  endfunction

  function automatic kind_t word_code(input wbuf_t w, input logic [15:0] len);
    logic hit;
    word_code = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (len == 16'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < int'(KW_LEN[k]) &&
            w[i] != KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8])
          hit = 1'b0;
      end
      if (hit) word_code = K_KEYWORD + 6'(k);
    end
  endfunction

endpackage

FILE: hw/rtl/script_source_tokenizer_core.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_data (char_in, end_of_source)
// out_    | output    | out_valid/out_stall | out_data (token or string byte)
//
// One byte is taken per cycle unless in_stall is high. An item can cause up to three
// results, which pass through the queue and then the output register and leave it one
// per cycle unless out_stall is high, so sustained input rate follows results.
// A four-entry queue between scanner and output parts sets how far input runs ahead.
// Reset restores line and column 1 and empties the queue and output register.
module script_source_tokenizer_core #(
  parameter int POSITION_BITS = sst_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::out_item_t out_data
);
  import sst_pkg::*;

  logic     q_push, q_full, q_nempty, q_pop;
  q_entry_t q_in, q_head;

  sst_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_full(q_full), .q_push(q_push), .q_data(q_in));

  sst_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .nempty(q_nempty), .pop(q_pop), .head(q_head));

  sst_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nempty(q_nempty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

endmodule

FILE: hw/rtl/sst_front.sv
module sst_front #(
  parameter int POSITION_BITS = sst_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sst_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output sst_pkg::q_entry_t q_data
);
  import sst_pkg::*;

  localparam int P = POSITION_BITS;
  localparam logic [P-1:0] PMAX = {P{1'b1}};
  localparam logic [P-1:0] PONE = P'(1);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_NUMI    = 4'd2;
  localparam logic [3:0] M_NUMD    = 4'd3;
  localparam logic [3:0] M_NUMF    = 4'd4;
  localparam logic [3:0] M_IDENT   = 4'd5;
  localparam logic [3:0] M_OPER    = 4'd6;
  localparam logic [3:0] M_DOLLAR  = 4'd7;
  localparam logic [3:0] M_STRING  = 4'd8;
  localparam logic [3:0] M_ESCAPE  = 4'd9;

  logic [3:0]   mode_r, mode_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         quote_r, quote_nxt;
  logic         interp_r, interp_nxt;
  logic [P-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [P-1:0] st_line_r, st_line_nxt, st_col_r, st_col_nxt;
  logic [15:0]  plen_r, plen_nxt;
  wbuf_t        wbuf_r, wbuf_nxt;

  logic                    accept;
  logic [1:0]              n;
  out_item_t [MAX_RES-1:0] res;
  logic [7:0]              c;
  logic                    go_idle;
  logic [32:0]             dot_sum;
  logic [P-1:0]            dot_col;
  logic [16:0]             plen_p1, plen_p2;
  kind_t                   str_kind, pk;

  function automatic logic [15:0] rep(input logic [P-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    rep = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic out_item_t mk(input logic rk, input kind_t k, input logic [7:0] b,
                                   input logic [15:0] l, input logic [15:0] col,
                                   input logic [15:0] len);
    mk = '{result_kind: rk, token_kind: k, text_byte: b, token_line: l,
           token_column: col, token_length: len, last_result: 1'b0};
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_data.char_in;
  assign str_kind = interp_r ? K_INTERP : K_STRING;
  assign plen_p1  = {1'b0, plen_r} + 17'd1;
  assign plen_p2  = {1'b0, plen_r} + 17'd2;
  assign dot_sum  = {1'b0, 32'(st_col_r)} + 33'(plen_r);
  assign dot_col  = (dot_sum > 33'(PMAX)) ? PMAX : dot_sum[P-1:0];
  assign pk       = pair_code(held_r, c);

  always_comb begin
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    quote_nxt    = quote_r;
    interp_nxt   = interp_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    st_line_nxt  = st_line_r;
    st_col_nxt   = st_col_r;
    plen_nxt     = plen_r;
    wbuf_nxt     = wbuf_r;
    n            = 2'd0;
    res          = '0;
    go_idle      = 1'b0;

    if (in_data.end_of_source) begin
      unique case (mode_r) inside
        M_NUMI, M_NUMF: begin
          res[n] = mk(1'b0, K_NUMBER, 8'd0, rep(st_line_r), rep(st_col_r), plen_r);
          n = n + 2'd1;
        end
        M_NUMD: begin
          res[n] = mk(1'b0, K_NUMBER, 8'd0, rep(st_line_r), rep(st_col_r), plen_r);
          n = n + 2'd1;
          res[n] = mk(1'b0, K_DOT, 8'd0, rep(st_line_r), rep(dot_col), 16'd1);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = mk(1'b0, word_code(wbuf_r, plen_r), 8'd0, rep(st_line_r),
                      rep(st_col_r), plen_r);
          n = n + 2'd1;
        end
        M_OPER: begin
          res[n] = mk(1'b0, alone_code(held_r), 8'd0, rep(st_line_r), rep(st_col_r), 16'd1);
          n = n + 2'd1;
        end
        M_DOLLAR: begin
          res[n] = mk(1'b0, K_ERROR, 8'd0, rep(st_line_r), rep(st_col_r), 16'd1);
          n = n + 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          res[n] = mk(1'b0, str_kind, 8'd0, rep(st_line_r), rep(st_col_r), plen_r);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = mk(1'b0, K_EOF, 8'd0, rep(cur_line_r), rep(cur_col_r), 16'd1);
      n = n + 2'd1;
      mode_nxt     = M_IDLE;
      held_nxt     = 8'd0;
      quote_nxt    = 1'b0;
      interp_nxt   = 1'b0;
      cur_line_nxt = PONE;
      cur_col_nxt  = PONE;
      st_line_nxt  = PONE;
      st_col_nxt   = PONE;
      plen_nxt     = 16'd0;
    end else begin
      unique case (mode_r) inside
        M_COMMENT: begin
          if (c == 8'h0A) go_idle = 1'b1;
        end
        M_NUMI, M_NUMF: begin
          if (is_digit(c)) begin
            plen_nxt = plen_p1[16] ? 16'hFFFF : plen_p1[15:0];
          end else if (c == "." && mode_r == M_NUMI) begin
            mode_nxt = M_NUMD;
          end else begin
            res[n] = mk(1'b0, K_NUMBER, 8'd0, rep(st_line_r), rep(st_col_r), plen_r);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_NUMD: begin
          if (is_digit(c)) begin
            plen_nxt = plen_p2[16] ? 16'hFFFF : plen_p2[15:0];
            mode_nxt = M_NUMF;
          end else begin
            res[n] = mk(1'b0, K_NUMBER, 8'd0, rep(st_line_r), rep(st_col_r), plen_r);
            n = n + 2'd1;
            res[n] = mk(1'b0, K_DOT, 8'd0, rep(st_line_r), rep(dot_col), 16'd1);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (plen_r < 16'(KW_CHARS)) wbuf_nxt[plen_r[$clog2(KW_CHARS)-1:0]] = c;
            plen_nxt = plen_p1[16] ? 16'hFFFF : plen_p1[15:0];
          end else begin
            res[n] = mk(1'b0, word_code(wbuf_r, plen_r), 8'd0, rep(st_line_r),
                        rep(st_col_r), plen_r);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_OPER: begin
          if (pk != K_NUMBER) begin
            res[n] = mk(1'b0, pk, 8'd0, rep(st_line_r), rep(st_col_r), 16'd2);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n] = mk(1'b0, alone_code(held_r), 8'd0, rep(st_line_r), rep(st_col_r), 16'd1);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_DOLLAR: begin
          if (c == 8'h22 || c == 8'h27) begin
            mode_nxt   = M_STRING;
            quote_nxt  = (c == 8'h27);
            interp_nxt = 1'b1;
            plen_nxt   = 16'd2;
          end else begin
            res[n] = mk(1'b0, K_ERROR, 8'd0, rep(st_line_r), rep(st_col_r), 16'd1);
            n = n + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_STRING: begin
          plen_nxt = plen_p1[16] ? 16'hFFFF : plen_p1[15:0];
          if (c == (quote_r ? 8'h27 : 8'h22)) begin
            res[n] = mk(1'b0, str_kind, 8'd0, rep(st_line_r), rep(st_col_r), plen_nxt);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == 8'h5C) begin
            mode_nxt = M_ESCAPE;
          end else begin
            res[n] = mk(1'b1, str_kind, c, rep(st_line_r), rep(st_col_r), 16'd0);
            n = n + 2'd1;
          end
        end
        M_ESCAPE: begin
          plen_nxt = plen_p1[16] ? 16'hFFFF : plen_p1[15:0];
          res[n] = mk(1'b1, str_kind,
                      (c == "n") ? 8'h0A : (c == "r") ? 8'h0D : (c == "t") ? 8'h09 : c,
                      rep(st_line_r), rep(st_col_r), 16'd0);
          n = n + 2'd1;
          mode_nxt = M_STRING;
        end
        default: go_idle = 1'b1;
      endcase

      if (go_idle) begin
        mode_nxt = M_IDLE;
        if (c == 8'h20 || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
          mode_nxt = M_IDLE;
        end else if (c == "#") begin
          mode_nxt = M_COMMENT;
        end else if (is_digit(c) || c == "$" || c == 8'h22 || c == 8'h27 ||
                     is_alpha(c) || c == "_" || is_held_op(c)) begin
          st_line_nxt = cur_line_r;
          st_col_nxt  = cur_col_r;
          plen_nxt    = 16'd1;
          if (is_digit(c)) begin
            mode_nxt = M_NUMI;
          end else if (c == "$") begin
            mode_nxt = M_DOLLAR;
          end else if (c == 8'h22 || c == 8'h27) begin
            mode_nxt   = M_STRING;
            quote_nxt  = (c == 8'h27);
            interp_nxt = 1'b0;
          end else if (is_held_op(c)) begin
            mode_nxt = M_OPER;
            held_nxt = c;
          end else begin
            mode_nxt    = M_IDENT;
            wbuf_nxt[0] = c;
          end
        end else begin
          res[n] = mk(1'b0, single_code(c), 8'd0, rep(cur_line_r), rep(cur_col_r), 16'd1);
          n = n + 2'd1;
        end
      end

      if (c == 8'h0A) begin
        cur_line_nxt = (cur_line_r == PMAX) ? PMAX : cur_line_r + PONE;
        cur_col_nxt  = PONE;
      end else begin
        cur_col_nxt = (cur_col_r == PMAX) ? PMAX : cur_col_r + PONE;
      end
    end

    if (n != 2'd0) res[n - 2'd1].last_result = 1'b1;
  end

  assign q_push     = accept && (n != 2'd0);
  assign q_data.cnt = n;
  assign q_data.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      held_r     <= 8'd0;
      quote_r    <= 1'b0;
      interp_r   <= 1'b0;
      cur_line_r <= PONE;
      cur_col_r  <= PONE;
      st_line_r  <= PONE;
      st_col_r   <= PONE;
      plen_r     <= 16'd0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      quote_r    <= quote_nxt;
      interp_r   <= interp_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      st_line_r  <= st_line_nxt;
      st_col_r   <= st_col_nxt;
      plen_r     <= plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) wbuf_r <= wbuf_nxt;
  end

endmodule

FILE: hw/rtl/sst_queue.sv
module sst_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sst_pkg::q_entry_t push_data,
  output logic              full,
  output logic              nempty,
  input  logic              pop,
  output sst_pkg::q_entry_t head
);
  import sst_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  q_entry_t      mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full   = (cnt_r == (AW+1)'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: hw/rtl/sst_back.sv
module sst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nempty,
  input  sst_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::out_item_t out_data
);
  import sst_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  out_item_t  data_r;
  logic       load, last;

  assign load      = q_nempty && (!valid_r || !out_stall);
  assign last      = (idx_r == q_head.cnt - 2'd1);
  assign q_pop     = load && last;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (load) data_r <= q_head.res[idx_r];
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  // scanner modes of the predictor
  typedef enum logic [3:0] {
    SM_IDLE, SM_COMMENT, SM_INT, SM_DOT, SM_FRAC, SM_WORD, SM_OPER, SM_DOLLAR,
    SM_STR, SM_ESC
  } scan_t;

  class token_scoreboard;
    out_item_t pending_results[$];
    int        errors;
    int        tokens_seen;
    int        bytes_seen;
    scan_t       mode;
    logic [7:0]  held;
    bit          single_q;
    bit          interp;
    logic [15:0] cur_line, cur_col, st_line, st_col, plen;
    logic [7:0]  word_buf[KW_CHARS];
    out_item_t   batch[$];

    function new();
      errors = 0;
      tokens_seen = 0;
      bytes_seen = 0;
      clear_position();
    endfunction

    function void clear_position();
      mode = SM_IDLE;
      held = 8'h00;
      single_q = 0;
      interp = 0;
      cur_line = 1;
      cur_col = 1;
      st_line = 1;
      st_col = 1;
      plen = 0;
    endfunction

    function void push(bit rk, kind_t k, logic [7:0] b, logic [15:0] ln,
                       logic [15:0] cl, logic [15:0] len);
      out_item_t r;
      r.result_kind = rk;
      r.token_kind = k;
      r.text_byte = b;
      r.token_line = ln;
      r.token_column = cl;
      r.token_length = len;
      r.last_result = 0;
      batch = {batch, r};
    endfunction

    function logic [15:0] sat_add(logic [15:0] v, int d);
      return (int'(v) + d > 16'hFFFF) ? 16'hFFFF : 16'(int'(v) + d);
    endfunction

    function kind_t classify_word();
      string kws[20] = '{"var", "func", "class", "return", "if", "else", "while",
        "for", "break", "continue", "new", "this", "try", "catch", "finally",
        "throw", "extends", "true", "false", "null"};
      bit hit;
      if (plen > KW_CHARS) return K_IDENT;
      for (int k = 0; k < 20; k++) begin
        if (kws[k].len() == int'(plen)) begin
          hit = 1;
          for (int i = 0; i < kws[k].len(); i++)
            if (word_buf[i] != kws[k][i]) hit = 0;
          if (hit) return kind_t'(K_KEYWORD + k);
        end
      end
      return K_IDENT;
    endfunction

    function kind_t single_kind(logic [7:0] c);
      case (c)
        "*": return K_STAR;
        "/": return K_SLASH;
        "%": return K_PERCENT;
        "(": return K_LPAREN;
        ")": return K_RPAREN;
        "{": return K_LBRACE;
        "}": return K_RBRACE;
        "[": return K_LBRACK;
        "]": return K_RBRACK;
        ".": return K_DOT;
        ",": return K_COMMA;
        ";": return K_SEMI;
        ":": return K_COLON;
        default: return K_ERROR;
      endcase
    endfunction

    function kind_t lone_op_kind(logic [7:0] h);
      case (h)
        "+": return K_PLUS;
        "-": return K_MINUS;
        "=": return K_ASSIGN;
        "!": return K_NOT;
        "<": return K_LT;
        ">": return K_GT;
        default: return K_ERROR;
      endcase
    endfunction

    function kind_t op_pair_kind(logic [7:0] h, logic [7:0] c);
      if (h == "+" && c == "=") return K_PLUSEQ;
      if (h == "-" && c == "=") return K_MINUSEQ;
      if (h == "-" && c == ">") return K_ARROW;
      if (h == "=" && c == "=") return K_EQ;
      if (h == "=" && c == ">") return K_FATARR;
      if (h == "!" && c == "=") return K_NE;
      if (h == "<" && c == "=") return K_LE;
      if (h == ">" && c == "=") return K_GE;
      if (h == "&" && c == "&") return K_ANDAND;
      if (h == "|" && c == "|") return K_OROR;
      if (h == "|" && c == ">") return K_PIPE;
      return K_NUMBER;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function kind_t str_kind();
      return interp ? K_INTERP : K_STRING;
    endfunction

    function void begin_token(scan_t m, logic [15:0] ln, logic [15:0] cl);
      mode = m;
      st_line = ln;
      st_col = cl;
      plen = 1;
    endfunction

    function void number_and_dot();
      int dc;
      dc = int'(st_col) + int'(plen);
      push(0, K_NUMBER, 0, st_line, st_col, plen);
      push(0, K_DOT, 0, st_line, dc > 16'hFFFF ? 16'hFFFF : 16'(dc), 1);
    endfunction

    function void from_idle(logic [7:0] c, logic [15:0] ln, logic [15:0] cl);
      mode = SM_IDLE;
      if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) return;
      if (c == "#") begin
        mode = SM_COMMENT;
      end else if (digit(c)) begin
        begin_token(SM_INT, ln, cl);
      end else if (c == "$") begin
        begin_token(SM_DOLLAR, ln, cl);
      end else if (c == "\"" || c == "'") begin
        begin_token(SM_STR, ln, cl);
        single_q = (c == "'");
        interp = 0;
      end else if (alpha(c) || c == "_") begin
        begin_token(SM_WORD, ln, cl);
        word_buf[0] = c;
      end else if (c inside {"+", "-", "=", "!", "<", ">", "&", "|"}) begin
        begin_token(SM_OPER, ln, cl);
        held = c;
      end else begin
        push(0, single_kind(c), 0, ln, cl, 1);
      end
    endfunction

    function void scan_byte(logic [7:0] c, logic [15:0] ln, logic [15:0] cl);
      kind_t p;
      logic [7:0] q;
      case (mode)
        SM_COMMENT: if (c == 8'h0A) from_idle(c, ln, cl);
        SM_INT, SM_FRAC: begin
          if (digit(c)) plen = sat_add(plen, 1);
          else if (c == "." && mode == SM_INT) mode = SM_DOT;
          else begin
            push(0, K_NUMBER, 0, st_line, st_col, plen);
            from_idle(c, ln, cl);
          end
        end
        SM_DOT: begin
          if (digit(c)) begin
            plen = sat_add(plen, 2);
            mode = SM_FRAC;
          end else begin
            number_and_dot();
            from_idle(c, ln, cl);
          end
        end
        SM_WORD: begin
          if (alpha(c) || digit(c) || c == "_") begin
            if (plen < KW_CHARS) word_buf[plen] = c;
            plen = sat_add(plen, 1);
          end else begin
            push(0, classify_word(), 0, st_line, st_col, plen);
            from_idle(c, ln, cl);
          end
        end
        SM_OPER: begin
          p = op_pair_kind(held, c);
          if (p != K_NUMBER) begin
            push(0, p, 0, st_line, st_col, 2);
            mode = SM_IDLE;
          end else begin
            push(0, lone_op_kind(held), 0, st_line, st_col, 1);
            from_idle(c, ln, cl);
          end
        end
        SM_DOLLAR: begin
          if (c == "\"" || c == "'") begin
            mode = SM_STR;
            single_q = (c == "'");
            interp = 1;
            plen = 2;
          end else begin
            push(0, K_ERROR, 0, st_line, st_col, 1);
            from_idle(c, ln, cl);
          end
        end
        SM_STR: begin
          plen = sat_add(plen, 1);
          if (c == (single_q ? "'" : "\"")) begin
            push(0, str_kind(), 0, st_line, st_col, plen);
            mode = SM_IDLE;
          end else if (c == "\\") begin
            mode = SM_ESC;
          end else begin
            push(1, str_kind(), c, st_line, st_col, 0);
          end
        end
        SM_ESC: begin
          plen = sat_add(plen, 1);
          q = (c == "n") ? 8'h0A : (c == "r") ? 8'h0D : (c == "t") ? 8'h09 : c;
          push(1, str_kind(), q, st_line, st_col, 0);
          mode = SM_STR;
        end
        default: from_idle(c, ln, cl);
      endcase
    endfunction

    function void flush_token();
      case (mode)
        SM_INT, SM_FRAC: push(0, K_NUMBER, 0, st_line, st_col, plen);
        SM_DOT: number_and_dot();
        SM_WORD: push(0, classify_word(), 0, st_line, st_col, plen);
        SM_OPER: push(0, lone_op_kind(held), 0, st_line, st_col, 1);
        SM_DOLLAR: push(0, K_ERROR, 0, st_line, st_col, 1);
        SM_STR, SM_ESC: push(0, str_kind(), 0, st_line, st_col, plen);
        default: ;
      endcase
    endfunction

    // note an accepted source transfer and queue what it should produce
    function void note_input(in_item_t it);
      logic [15:0] ln, cl;
      ln = cur_line;
      cl = cur_col;
      batch.delete();
      if (it.end_of_source) begin
        flush_token();
        push(0, K_EOF, 0, ln, cl, 1);
        clear_position();
      end else begin
        scan_byte(it.char_in, ln, cl);
        if (it.char_in == 8'h0A) begin
          cur_line = sat_add(cur_line, 1);
          cur_col = 1;
        end else begin
          cur_col = sat_add(cur_col, 1);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last_result = 1;
      foreach (batch[i]) pending_results = {pending_results, batch[i]};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.result_kind) bytes_seen++;
      else tokens_seen++;
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;

  token_scoreboard sb = new();
  bit hold_output = 0;
  int hold_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  script_source_tokenizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // check the result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // random stalls on the result side, with one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_output) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles + 1;
    end else if ($urandom_range(0, 99) < 20) begin
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // valid stays high after a transfer; the next gap or item decides what follows
  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    repeat (g) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_byte(logic [7:0] c);
    in_item_t it;
    it.char_in = c;
    it.end_of_source = 0;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it.char_in = 8'($urandom);
    it.end_of_source = 1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function string pick_fragment();
    string frags[30] = '{"var ", "func", "class", "return", "if", "else", "while",
      "for", "break", "continue", "new", "this", "try", "catch", "finally",
      "throw", "extends", "true", "false", "null", "continuex", "abc_9", "_",
      "12.5", "7.", "3", "+= -> => == != <= >= && || |>", "\"a\\nb\"",
      "$'x\\'y'", "# note\n"};
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return frags[$urandom_range(0, 29)];
    if (r < 8) return " \t\n";
    return "+-=!<>&|*/%(){}[].,;:$";
  endfunction

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    string s;
    int sent;
    in_item_t it;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: keywords, numbers, strings, operators and odd bytes
    send_text("if x1 >= 9.25 {a.b}\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$x 3.q & |");
    send_end();
    send_text("\"t\\tq");
    send_end();

    // long hold-off on the result side while input keeps coming
    hold_output = 1;
    fork
      begin
        while (hold_cycles < 60) @(posedge clk);
        hold_output = 0;
      end
      send_text("(,);:*/%[]");
    join

    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(0, 9) < 8) begin
        s = pick_fragment();
        send_text(s);
        sent += s.len();
      end else if ($urandom_range(0, 4) == 0) begin
        send_end();
        sent++;
      end else begin
        it = in_item_t'(9'($urandom));
        it.end_of_source = 0;
        send_item(it);
        sent++;
      end
    end
    send_end();
    in_valid <= 0;

    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d tokens and %0d string bytes over keywords, numbers, strings,",
             sb.tokens_seen, sb.bytes_seen);
    $display("operators, comments, error bytes and end-of-source flushes.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
